// ===== src/sorted_list_merge_defines.svh =====
// Assertion macros shared by the merge block's modules.
`ifndef SORTED_LIST_MERGE_DEFINES_SVH
`define SORTED_LIST_MERGE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slm_pkg.sv =====
package slm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int DATA_W     = 32;
  localparam int PTR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

  localparam logic [1:0] OP_PUSH_A = 2'd0;
  localparam logic [1:0] OP_PUSH_B = 2'd1;
  localparam logic [1:0] OP_TAKE   = 2'd2;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_GIVEN    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] merged_value;
    logic                     from_list_b;
  } out_item_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
  } cmd_t;

endpackage

// ===== src/slm_datapath.sv =====
`include "sorted_list_merge_defines.svh"

module slm_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  slm_pkg::in_item_t in_data,
  input  slm_pkg::cmd_t     cmd,
  output slm_pkg::out_item_t out_data
);
  import slm_pkg::*;

  logic [DATA_W-1:0] mem_a [LIST_DEPTH];
  logic [DATA_W-1:0] mem_b [LIST_DEPTH];

  in_item_t          item_r;
  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic [PTR_W-1:0]  head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic [CNT_W-1:0]  count_a_r, count_a_nxt, count_b_r, count_b_nxt;
  out_item_t         out_r, out_nxt;

  logic              wr_a, wr_b;
  logic [PTR_W-1:0]  tail_a, tail_b;
  logic              has_a, has_b, take_a, is_take;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] offs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
    if (sum >= (CNT_W+1)'(LIST_DEPTH)) begin
      sum = sum - (CNT_W+1)'(LIST_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign tail_a  = wrap_add(head_a_r, count_a_r);
  assign tail_b  = wrap_add(head_b_r, count_b_r);
  assign has_a   = (count_a_r != '0);
  assign has_b   = (count_b_r != '0);
  assign is_take = (item_r.op != OP_PUSH_A) && (item_r.op != OP_PUSH_B);
  // Ties go to list B, so A wins only on a strict less-than.
  assign take_a  = has_a && (!has_b || ($signed(rd_a_r) < $signed(rd_b_r)));

  always_comb begin
    head_a_nxt  = head_a_r;
    head_b_nxt  = head_b_r;
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    out_nxt     = out_r;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    if (cmd.load) begin
      out_nxt.merged_value = '0;
      out_nxt.from_list_b  = 1'b0;
      if (item_r.op == OP_PUSH_A) begin
        if (count_a_r == CNT_FULL) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.status = ST_ACCEPTED;
          wr_a           = 1'b1;
          count_a_nxt    = count_a_r + CNT_W'(1);
        end
      end else if (item_r.op == OP_PUSH_B) begin
        if (count_b_r == CNT_FULL) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.status = ST_ACCEPTED;
          wr_b           = 1'b1;
          count_b_nxt    = count_b_r + CNT_W'(1);
        end
      end else if (!has_a && !has_b) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        out_nxt.status = ST_GIVEN;
        if (take_a) begin
          out_nxt.merged_value = $signed(rd_a_r);
          head_a_nxt           = wrap_add(head_a_r, CNT_W'(1));
          count_a_nxt          = count_a_r - CNT_W'(1);
        end else begin
          out_nxt.merged_value = $signed(rd_b_r);
          out_nxt.from_list_b  = 1'b1;
          head_b_nxt           = wrap_add(head_b_r, CNT_W'(1));
          count_b_nxt          = count_b_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_a_r  <= '0;
      head_b_r  <= '0;
      count_a_r <= '0;
      count_b_r <= '0;
    end else begin
      head_a_r  <= head_a_nxt;
      head_b_r  <= head_b_nxt;
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  // The head entries are read every cycle, so the registered data follows each transfer.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[tail_a] <= item_r.value;
    end
    if (wr_b) begin
      mem_b[tail_b] <= item_r.value;
    end
    rd_a_r <= mem_a[head_a_r];
    rd_b_r <= mem_b[head_b_r];
  end

  assign out_data = out_r;

  `SLM_ASSERT_NOW(a_count_range, 1'b1,
    (count_a_r <= CNT_FULL) && (count_b_r <= CNT_FULL), "queue count beyond depth")
  `SLM_ASSERT_NEXT(a_empty_take, cmd.load && is_take && !has_a && !has_b,
    (out_r.status == ST_EMPTY) && (out_r.merged_value == '0), "empty take misreported")
  `SLM_ASSERT_NEXT(a_take_pops_one, cmd.load && is_take && (has_a || has_b),
    ((CNT_W+1)'(count_a_r) + (CNT_W+1)'(count_b_r) + (CNT_W+1)'(1)) ==
    ((CNT_W+1)'($past(count_a_r)) + (CNT_W+1)'($past(count_b_r))),
    "take did not remove exactly one entry")

endmodule

// ===== src/slm_ctrl.sv =====
`include "sorted_list_merge_defines.svh"

module slm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output slm_pkg::cmd_t cmd
);
  import slm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy;

  // The result register is free when empty or being drained this cycle.
  assign out_busy = out_valid_r && !out_ready;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.load      = 1'b0;
    out_valid_nxt = out_busy;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_busy) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SLM_ASSERT_NEXT(a_load_shows_result, cmd.load, out_valid_r, "loaded result not shown")
  `SLM_ASSERT_NOW(a_no_overwrite, cmd.load, !out_busy, "result overwritten before transfer")
  `SLM_ASSERT_NEXT(a_capture_then_exec, rst_n && cmd.capture, state_r == S_EXEC,
    "captured item not executed")

endmodule

// ===== src/sorted_list_merge.sv =====
// Each item is captured in the idle state, while both queue heads are read from the
// registered-read memories; the exec state then compares, updates the queue and loads the result.
// A new item is taken only after the last has loaded its result; exec waits while a result is held.
// Results show in the cycle after the load; a new item is taken while a result waits.
// Synchronous active-low reset empties both queues; queue memory contents are not cleared.
module sorted_list_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output slm_pkg::out_item_t out_data
);
  import slm_pkg::*;

  cmd_t cmd;

  slm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  slm_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

// ===== tb/tb_sorted_list_merge.sv =====
`timescale 1ns / 1ps

module tb_sorted_list_merge;
  import slm_pkg::*;

  localparam int                 ITEM_TARGET     = 1200;
  localparam int                 HOLD_OFF_CYCLES = 400;
  localparam int                 SETTLE_CYCLES   = 10;
  localparam int                 REPORT_LIMIT    = 10;
  localparam logic [1:0]         OP_SPARE        = 2'd3;
  localparam logic [DATA_W-1:0]  VAL_MIN         = 32'h8000_0000;
  localparam logic [DATA_W-1:0]  VAL_MAX         = 32'h7FFF_FFFF;

  // Keeps its own copy of both queues and predicts the reply to each accepted transfer.
  class merge_scoreboard;
    logic signed [DATA_W-1:0] list_a[$];
    logic signed [DATA_W-1:0] list_b[$];
    out_item_t                replies_due[$];
    int                       mismatches;
    int                       results_seen;
    int                       merged_count;
    int                       tie_count;
    int                       full_count;
    int                       empty_count;

    function void note_accepted(in_item_t item);
      out_item_t reply;
      bit        take_a;
      reply = '0;
      if (item.op == OP_PUSH_A) begin
        if (list_a.size() >= LIST_DEPTH) begin
          reply.status = ST_FULL;
          full_count++;
        end else begin
          list_a.push_back(item.value);
          reply.status = ST_ACCEPTED;
        end
      end else if (item.op == OP_PUSH_B) begin
        if (list_b.size() >= LIST_DEPTH) begin
          reply.status = ST_FULL;
          full_count++;
        end else begin
          list_b.push_back(item.value);
          reply.status = ST_ACCEPTED;
        end
      end else if (list_a.size() == 0 && list_b.size() == 0) begin
        // The spare code decodes as a take as well.
        reply.status = ST_EMPTY;
        empty_count++;
      end else begin
        take_a = list_a.size() != 0 && (list_b.size() == 0 || list_a[0] < list_b[0]);
        if (list_a.size() != 0 && list_b.size() != 0 && list_a[0] == list_b[0])
          tie_count++;
        if (take_a) begin
          reply.merged_value = list_a.pop_front();
        end else begin
          reply.merged_value = list_b.pop_front();
          reply.from_list_b  = 1'b1;
        end
        reply.status = ST_GIVEN;
        merged_count++;
      end
      replies_due.push_back(reply);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected result: status %0d value %0d from_b %0d",
                   $time, got.status, got.merged_value, got.from_list_b);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status || got.merged_value !== want.merged_value ||
          got.from_list_b !== want.from_list_b) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] mismatch: want status %0d value %0d from_b %0d, got %0d %0d %0d",
                   $time, want.status, want.merged_value, want.from_list_b,
                   got.status, got.merged_value, got.from_list_b);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  merge_scoreboard board;
  int              items_sent;
  int              input_stalls;
  int              hold_off_done;

  sorted_list_merge DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  bit sender_calm;

  // Called at a rising edge; returns at the edge where the transfer happened, or at the
  // end of the idle gap that follows it.
  task automatic send_item(input logic [1:0] op, input logic [DATA_W-1:0] value);
    in_item_t item;
    int       gap;
    item.op    = op;
    item.value = value;
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
      if (!in_ready) input_stalls++;
    end while (!in_ready);
    board.note_accepted(item);
    items_sent++;
    gap = sender_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_take();
    send_item(($urandom_range(0, 4) == 0) ? OP_SPARE : OP_TAKE, $urandom);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(input int kind, input int base);
    case (kind)
      5, 6, 7: return base + $urandom_range(0, 15);
      8: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Pushes two lists, ascending unless the batch is noise, then drains them to at most eight entries.
  task automatic run_batch(input int len_a, input int len_b);
    int vals_a[$];
    int vals_b[$];
    int kind;
    int base;
    int ia;
    int ib;
    int keep;
    bit mixed;
    kind = $urandom_range(0, 9);
    base = $urandom;
    sender_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len_a; i++) vals_a.push_back(pick_value(kind, base));
    for (int i = 0; i < len_b; i++) vals_b.push_back(pick_value(kind, base));
    if (kind != 9) begin
      vals_a.sort();
      vals_b.sort();
    end
    mixed = ($urandom_range(0, 2) == 0);
    ia = 0;
    ib = 0;
    while (ia < vals_a.size() || ib < vals_b.size()) begin
      if (mixed && $urandom_range(0, 4) == 0) begin
        send_take();
      end else if (ib >= vals_b.size() || (ia < vals_a.size() && $urandom_range(0, 1))) begin
        send_item(OP_PUSH_A, vals_a[ia]);
        ia++;
      end else begin
        send_item(OP_PUSH_B, vals_b[ib]);
        ib++;
      end
    end
    keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    while (board.list_a.size() + board.list_b.size() > keep) send_take();
    repeat ($urandom_range(0, 2)) send_take();
  endtask

  function automatic int batch_len();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(25, 36);
  endfunction

  initial begin
    #10_000_000;
    $display("timeout with %0d replies outstanding", board.replies_due.size());
    $display("tb_sorted_list_merge: FAIL");
    $finish;
  end

  // Result side: random stalls, calm stretches, and one long hold-off.
  initial begin : result_sink
    int stall_left;
    int calm_left;
    bit calm;
    stall_left = 0;
    calm_left  = 0;
    calm       = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_result(out_data);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      if (hold_off_done == 0 && board.results_seen >= 300) begin
        hold_off_done = 1;
        stall_left    = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = calm ? 0 : gap_len();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    int leftover;
    board         = new();
    items_sent    = 0;
    input_stalls  = 0;
    hold_off_done = 0;
    sender_calm   = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Takes on empty queues, with both take codes.
    send_item(OP_TAKE, '0);
    send_item(OP_SPARE, '1);
    // Extremes of the value range.
    send_item(OP_PUSH_A, VAL_MIN);
    send_item(OP_PUSH_B, VAL_MAX);
    send_item(OP_TAKE, VAL_MAX);
    send_item(OP_TAKE, VAL_MIN);
    // Equal heads: list B wins.
    send_item(OP_PUSH_A, '0);
    send_item(OP_PUSH_B, '0);
    send_item(OP_TAKE, 32'h5555_5555);
    send_item(OP_TAKE, 32'hAAAA_AAAA);
    // Negative against positive heads, then an unsorted list B.
    send_item(OP_PUSH_A, '1);
    send_item(OP_PUSH_B, 32'h5555_5555);
    send_item(OP_PUSH_A, VAL_MAX);
    send_item(OP_PUSH_B, VAL_MIN);
    send_item(OP_TAKE, '0);
    send_item(OP_TAKE, '0);
    send_item(OP_TAKE, '0);
    send_item(OP_SPARE, '0);
    send_item(OP_TAKE, '0);
    send_item(OP_PUSH_B, 32'hAAAA_AAAA);
    send_item(OP_SPARE, 32'h1234_5678);
    send_item(OP_SPARE, '0);

    // Overfill list A early so the full case is likely to be reached.
    run_batch(LIST_DEPTH + 2, 3);
    while (items_sent < ITEM_TARGET) run_batch(batch_len(), batch_len());
    in_valid <= 1'b0;

    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    leftover = board.replies_due.size();
    $display("%0d transfers in, %0d results; %0d merged (%0d ties), %0d full, %0d empty",
             items_sent, board.results_seen, board.merged_count, board.tie_count,
             board.full_count, board.empty_count);
    $display("input held back for %0d cycles, one result-side hold-off of %0d cycles",
             input_stalls, HOLD_OFF_CYCLES);
    if (board.mismatches == 0 && leftover == 0) begin
      $display("tb_sorted_list_merge: PASS");
    end else begin
      $display("%0d mismatches, %0d replies never seen", board.mismatches, leftover);
      $display("tb_sorted_list_merge: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/slm_pkg.sv
src/slm_datapath.sv
src/slm_ctrl.sv
src/sorted_list_merge.sv
tb/tb_sorted_list_merge.sv
